// ===== src/tch_pkg.sv =====
package tch_pkg;

   // Fixed widths of the ports
   localparam int SAMPLE_WIDTH = 16;
   localparam int ANGLE_W      = 16;
   localparam int CORDIC_STEPS = 16;

   // Angle table depth and step index width
   localparam int ATAN_ENTRIES = 24;
   localparam int STEP_W       = $clog2(ATAN_ENTRIES);

   // Internal formats: Q30 trig, Q30 angles
   localparam int TRIG_W = 32;
   localparam int ZR_W   = 34;
   localparam int TP_W   = 2 * TRIG_W;
   localparam int FP_W   = SAMPLE_WIDTH + TRIG_W;
   localparam int H_W    = SAMPLE_WIDTH + TRIG_W - 12;
   localparam int VX_W   = H_W + 3;
   localparam int VZ_W   = 34;

   localparam logic signed [TRIG_W-1:0] INV_GAIN_Q30 = 32'sd652032874;
   localparam logic signed [ZR_W-1:0]   HALF_PI_Q30  = 34'sd1686629713;
   localparam logic signed [ZR_W-1:0]   PI_Q30       = 34'sd3373259426;
   localparam logic signed [ANGLE_W-1:0] PI_Q13      = 16'sd25736;

   typedef struct packed {
      logic signed [TRIG_W-1:0] x;
      logic signed [TRIG_W-1:0] y;
      logic signed [ZR_W-1:0]   z;
      logic                     neg;
   } trig_type;

   typedef struct packed {
      trig_type                       roll;
      trig_type                       pitch;
      logic signed [SAMPLE_WIDTH-1:0] fx;
      logic signed [SAMPLE_WIDTH-1:0] fy;
      logic signed [SAMPLE_WIDTH-1:0] fz;
   } rot_state_type;

   typedef struct packed {
      logic signed [VX_W-1:0] x;
      logic signed [VX_W-1:0] y;
      logic signed [VZ_W-1:0] z;
      logic                   degen;
   } vec_state_type;

   // Elementary angles atan(2^-i), Q30
   function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:    r = 32'h3243F6A8;
         5'd1:    r = 32'h1DAC6705;
         5'd2:    r = 32'h0FADBAFC;
         5'd3:    r = 32'h07F56EA6;
         5'd4:    r = 32'h03FEAB76;
         5'd5:    r = 32'h01FFD55B;
         5'd6:    r = 32'h00FFFAAA;
         5'd7:    r = 32'h007FFF55;
         5'd8:    r = 32'h003FFFEA;
         5'd9:    r = 32'h001FFFFD;
         5'd10:   r = 32'h000FFFFF;
         5'd11:   r = 32'h0007FFFF;
         5'd12:   r = 32'h0003FFFF;
         5'd13:   r = 32'h0001FFFF;
         5'd14:   r = 32'h0000FFFF;
         5'd15:   r = 32'h00007FFF;
         5'd16:   r = 32'h00003FFF;
         5'd17:   r = 32'h00001FFF;
         5'd18:   r = 32'h00000FFF;
         5'd19:   r = 32'h000007FF;
         5'd20:   r = 32'h000003FF;
         5'd21:   r = 32'h000001FF;
         5'd22:   r = 32'h000000FF;
         5'd23:   r = 32'h0000007F;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // One rotation-mode micro-rotation
   function automatic trig_type rot_step(input trig_type t, input logic [STEP_W-1:0] idx);
      trig_type r;
      logic signed [ZR_W-1:0] a;
      a = ZR_W'(atan_q30(idx));
      r = t;
      if (t.z >= 0) begin
         r.x = t.x - (t.y >>> idx);
         r.y = t.y + (t.x >>> idx);
         r.z = t.z - a;
      end else begin
         r.x = t.x + (t.y >>> idx);
         r.y = t.y - (t.x >>> idx);
         r.z = t.z + a;
      end
      return r;
   endfunction

endpackage

// ===== src/tilt_compensated_heading.sv =====
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   field_x, field_y, field_z, roll_angle, pitch_angle
// rsp_      out        rsp_valid/rsp_ready   heading_angle, degenerate_field
//
// One transfer per cycle sustained while rsp_ready is high; the pipeline is made up of
// the two chains of CORDIC cells, three product stages and the output register.
// Synchronous active-high reset clears every valid bit; payload registers are not reset.
// Each stage holds while the next is full and stalled, so bubbles close up and the input
// keeps being taken while a result waits on rsp_ready, until the pipeline has filled.
module tilt_compensated_heading (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [tch_pkg::SAMPLE_WIDTH-1:0]  req_field_x,
   input  logic signed [tch_pkg::SAMPLE_WIDTH-1:0]  req_field_y,
   input  logic signed [tch_pkg::SAMPLE_WIDTH-1:0]  req_field_z,
   input  logic signed [tch_pkg::ANGLE_W-1:0]       req_roll_angle,
   input  logic signed [tch_pkg::ANGLE_W-1:0]       req_pitch_angle,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [tch_pkg::ANGLE_W-1:0]       rsp_heading_angle,
   output logic                                     rsp_degenerate_field
);

   localparam int N  = tch_pkg::CORDIC_STEPS;
   localparam int ZW = tch_pkg::ZR_W;
   localparam int VZ = tch_pkg::VZ_W;

   // Reduce an angle into +-pi/2 and seed the rotation
   function automatic tch_pkg::trig_type seed(input logic signed [tch_pkg::ANGLE_W-1:0] ang);
      tch_pkg::trig_type t;
      logic signed [ZW-1:0] z;
      z     = ZW'(ang) <<< 17;
      t.x   = tch_pkg::INV_GAIN_Q30;
      t.y   = '0;
      t.z   = z;
      t.neg = 1'b0;
      if (z > tch_pkg::HALF_PI_Q30) begin
         t.z   = z - tch_pkg::PI_Q30;
         t.neg = 1'b1;
      end else if (z < -tch_pkg::HALF_PI_Q30) begin
         t.z   = z + tch_pkg::PI_Q30;
         t.neg = 1'b1;
      end
      return t;
   endfunction

   // Rotation chain
   tch_pkg::rot_state_type rot_bus [0:N];
   logic                   rot_valid [0:N];
   logic                   rot_ready [0:N];

   always_comb begin
      rot_bus[0].roll  = seed(req_roll_angle);
      rot_bus[0].pitch = seed(req_pitch_angle);
      rot_bus[0].fx    = req_field_x;
      rot_bus[0].fy    = req_field_y;
      rot_bus[0].fz    = req_field_z;
   end
   assign rot_valid[0] = req_valid;
   assign req_ready    = rot_ready[0];

   for (genvar gi = 0; gi < N; gi++) begin : g_rot
      tch_rot_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (tch_pkg::STEP_W'(gi)),
         .in_valid  (rot_valid[gi]),
         .in_ready  (rot_ready[gi]),
         .in_state  (rot_bus[gi]),
         .out_valid (rot_valid[gi+1]),
         .out_ready (rot_ready[gi+1]),
         .out_state (rot_bus[gi+1])
      );
   end

   // Tilt compensation products
   tch_pkg::vec_state_type vec_bus [0:N];
   logic                   vec_valid [0:N];
   logic                   vec_ready [0:N];

   tch_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid[N]),
      .in_ready  (rot_ready[N]),
      .in_state  (rot_bus[N]),
      .out_valid (vec_valid[0]),
      .out_ready (vec_ready[0]),
      .out_state (vec_bus[0])
   );

   // Vectoring chain
   for (genvar gj = 0; gj < N; gj++) begin : g_vec
      tch_vec_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (tch_pkg::STEP_W'(gj)),
         .in_valid  (vec_valid[gj]),
         .in_ready  (vec_ready[gj]),
         .in_state  (vec_bus[gj]),
         .out_valid (vec_valid[gj+1]),
         .out_ready (vec_ready[gj+1]),
         .out_state (vec_bus[gj+1])
      );
   end

   // Round to Q13 and saturate at +-pi; a degenerate field gives zero
   logic signed [VZ:0]                   rounded;
   logic signed [tch_pkg::ANGLE_W-1:0]   head_in;
   logic                                 out_valid_ff;
   logic signed [tch_pkg::ANGLE_W-1:0]   head_ff;
   logic                                 degen_ff;

   assign rounded = ((VZ+1)'(vec_bus[N].z) + (VZ+1)'(65536)) >>> 17;

   always_comb begin
      if (vec_bus[N].degen) begin
         head_in = '0;
      end else if (rounded > (VZ+1)'(tch_pkg::PI_Q13)) begin
         head_in = tch_pkg::PI_Q13;
      end else if (rounded < -((VZ+1)'(tch_pkg::PI_Q13))) begin
         head_in = -tch_pkg::PI_Q13;
      end else begin
         head_in = tch_pkg::ANGLE_W'(rounded);
      end
   end

   assign vec_ready[N] = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (vec_ready[N]) begin
         out_valid_ff <= vec_valid[N];
      end
      if (vec_ready[N] && vec_valid[N]) begin
         head_ff  <= head_in;
         degen_ff <= vec_bus[N].degen;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_heading_angle    = head_ff;
   assign rsp_degenerate_field = degen_ff;

endmodule

// ===== src/tch_rot_cell.sv =====
module tch_rot_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tch_pkg::STEP_W-1:0]    step_idx,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  tch_pkg::rot_state_type        in_state,
   output logic                          out_valid,
   input  logic                          out_ready,
   output tch_pkg::rot_state_type        out_state
);

   logic                   valid_ff;
   tch_pkg::rot_state_type state_ff;
   tch_pkg::rot_state_type state_in;

   // Rotate roll and pitch by one step, pass samples along
   always_comb begin
      state_in       = in_state;
      state_in.roll  = tch_pkg::rot_step(in_state.roll, step_idx);
      state_in.pitch = tch_pkg::rot_step(in_state.pitch, step_idx);
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance when downstream has room
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// ===== src/tch_vec_cell.sv =====
module tch_vec_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tch_pkg::STEP_W-1:0]    step_idx,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  tch_pkg::vec_state_type        in_state,
   output logic                          out_valid,
   input  logic                          out_ready,
   output tch_pkg::vec_state_type        out_state
);

   logic                   valid_ff;
   tch_pkg::vec_state_type state_ff;
   tch_pkg::vec_state_type state_in;
   logic signed [tch_pkg::VZ_W-1:0] a;

   // Drive y towards zero, accumulate the angle
   always_comb begin
      a        = tch_pkg::VZ_W'(tch_pkg::atan_q30(step_idx));
      state_in = in_state;
      if (in_state.y >= 0) begin
         state_in.x = in_state.x + (in_state.y >>> step_idx);
         state_in.y = in_state.y - (in_state.x >>> step_idx);
         state_in.z = in_state.z + a;
      end else begin
         state_in.x = in_state.x - (in_state.y >>> step_idx);
         state_in.y = in_state.y + (in_state.x >>> step_idx);
         state_in.z = in_state.z - a;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// ===== src/tch_mix.sv =====
module tch_mix (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tch_pkg::rot_state_type in_state,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tch_pkg::vec_state_type out_state
);

   localparam int TW = tch_pkg::TRIG_W;
   localparam int SW = tch_pkg::SAMPLE_WIDTH;
   localparam int HW = tch_pkg::H_W;
   localparam int XW = tch_pkg::VX_W;

   // Stage one: sines, cosines and first products
   logic signed [TW-1:0] sr, cr, sp, cp;
   logic                 v1_ff;
   logic                 rdy1, rdy2, rdy3;
   logic signed [tch_pkg::TP_W-1:0] srsp_p_ff, srcp_p_ff;
   logic signed [tch_pkg::FP_W-1:0] xc_ff, zs_ff, yc_ff;
   logic signed [SW-1:0]            fx1_ff, fz1_ff;

   assign sr = in_state.roll.neg  ? -in_state.roll.y  : in_state.roll.y;
   assign cr = in_state.roll.neg  ? -in_state.roll.x  : in_state.roll.x;
   assign sp = in_state.pitch.neg ? -in_state.pitch.y : in_state.pitch.y;
   assign cp = in_state.pitch.neg ? -in_state.pitch.x : in_state.pitch.x;

   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= in_valid;
      end
      if (rdy1 && in_valid) begin
         srsp_p_ff <= tch_pkg::TP_W'(sr) * tch_pkg::TP_W'(sp);
         srcp_p_ff <= tch_pkg::TP_W'(sr) * tch_pkg::TP_W'(cp);
         xc_ff     <= tch_pkg::FP_W'(in_state.fx) * tch_pkg::FP_W'(cp);
         zs_ff     <= tch_pkg::FP_W'(in_state.fz) * tch_pkg::FP_W'(sp);
         yc_ff     <= tch_pkg::FP_W'(in_state.fy) * tch_pkg::FP_W'(cr);
         fx1_ff    <= in_state.fx;
         fz1_ff    <= in_state.fz;
      end
   end

   // Stage two: cross products, hx sum
   logic signed [TW-1:0]            srsp, srcp;
   logic                            v2_ff;
   logic signed [tch_pkg::FP_W-1:0] xsp_ff, zcp_ff;
   logic signed [HW-1:0]            hx_ff, yt_ff;

   assign srsp = TW'(srsp_p_ff >>> 30);
   assign srcp = TW'(srcp_p_ff >>> 30);
   assign rdy2 = !v2_ff || rdy3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
      if (rdy2 && v1_ff) begin
         xsp_ff <= tch_pkg::FP_W'(fx1_ff) * tch_pkg::FP_W'(srsp);
         zcp_ff <= tch_pkg::FP_W'(fz1_ff) * tch_pkg::FP_W'(srcp);
         hx_ff  <= HW'(xc_ff >>> 14) + HW'(zs_ff >>> 14);
         yt_ff  <= HW'(yc_ff >>> 14);
      end
   end

   // Stage three: hy sum, zero check, move into the right half plane
   logic signed [HW-1:0]   hy;
   logic signed [XW-1:0]   ex, ey;
   logic                   v3_ff;
   tch_pkg::vec_state_type vs_ff;
   tch_pkg::vec_state_type vs_in;

   assign hy = HW'(xsp_ff >>> 14) + yt_ff - HW'(zcp_ff >>> 14);
   assign ex = XW'(hx_ff);
   assign ey = XW'(hy);

   always_comb begin
      vs_in.degen = (hx_ff == '0) && (hy == '0);
      vs_in.x     = ex;
      vs_in.y     = ey;
      vs_in.z     = '0;
      if (hx_ff < 0) begin
         if (hy >= 0) begin
            vs_in.x = ey;
            vs_in.y = -ex;
            vs_in.z = tch_pkg::VZ_W'(tch_pkg::HALF_PI_Q30);
         end else begin
            vs_in.x = -ey;
            vs_in.y = ex;
            vs_in.z = -tch_pkg::VZ_W'(tch_pkg::HALF_PI_Q30);
         end
      end
   end

   assign rdy3 = !v3_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
      if (rdy3 && v2_ff) begin
         vs_ff <= vs_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_state = vs_ff;

endmodule
